### sv/resample_pan_gain_top_defines.svh
// Assertion macros for the resample/pan/gain block.
`ifndef RESAMPLE_PAN_GAIN_TOP_DEFINES_SVH
`define RESAMPLE_PAN_GAIN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RPG_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RPG_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define RPG_ASSERT(name, prop, msg)
`define RPG_NEVER(name, expr, msg)
`endif

`endif

### sv/rpg_pkg.sv
`default_nettype none
package rpg_pkg;

	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int PHASE_FRAC_BITS_DEF = 16;
	localparam int MAX_OUT_LOG2        = 6;
	localparam int GAIN_W              = 16;
	localparam int GAIN_SHIFT          = 15;
	localparam int ADDR_W              = 4;
	localparam int DATA_W              = 32;
	localparam int PAN_W               = 17;

	localparam logic [GAIN_W-1:0] GAIN_ONE     = 16'h8000;
	localparam logic [GAIN_W-1:0] VOLUME_RESET = 16'h8000;

	typedef enum logic [1:0] {
		REG_RATE_STEP = 2'd0,
		REG_VOLUME    = 2'd1,
		REG_PAN       = 2'd2,
		REG_MONO      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] vol;
		logic [GAIN_W-1:0] pan_l;
		logic [GAIN_W-1:0] pan_r;
		logic              mono;
	} rpg_gain_t;

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic signed [PAN_W:0] g);
		logic [GAIN_W-1:0] r;
		if (g < 0) begin
			r = '0;
		end else if (g > $signed({2'b00, GAIN_ONE})) begin
			r = GAIN_ONE;
		end else begin
			r = g[GAIN_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/rpg_core.sv
`default_nettype none
`include "resample_pan_gain_top_defines.svh"
module rpg_core
	import rpg_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rpg_gain_t                     gain,
	input  wire logic [PHASE_FRAC_BITS+4:0]    rate_step,
	input  wire logic                          src_valid,
	output logic                               src_stall,
	input  wire logic                          kind,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic signed [SAMPLE_BITS-1:0]      out_left,
	output logic signed [SAMPLE_BITS-1:0]      out_right,
	output logic                               last,
	output logic                               stream_done
);

	localparam int RATE_W = PHASE_FRAC_BITS + 5;
	localparam int PH_W   = PHASE_FRAC_BITS + 6;
	localparam int MA_W   = (SAMPLE_BITS > GAIN_W ? SAMPLE_BITS : GAIN_W) + 1;
	localparam int MB_W   = GAIN_W + 1;
	localparam int PROD_W = MA_W + MB_W;

	localparam logic [PH_W-1:0]   PH_ONE   = PH_W'(1) << PHASE_FRAC_BITS;
	localparam logic [RATE_W-1:0] MIN_STEP = RATE_W'(1) << (PHASE_FRAC_BITS - MAX_OUT_LOG2);
	localparam logic [MAX_OUT_LOG2-1:0] CNT_MAX = '1;
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_GL   = 8'b0000_0010,
		S_GR   = 8'b0000_0100,
		S_ML   = 8'b0000_1000,
		S_MR   = 8'b0001_0000,
		S_CAP  = 8'b0010_0000,
		S_EMIT = 8'b0100_0000,
		S_EOS  = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [PH_W-1:0]                 phase_q;
	logic [MAX_OUT_LOG2-1:0]         cnt_q;
	logic signed [SAMPLE_BITS-1:0]   ls_q;
	logic signed [SAMPLE_BITS-1:0]   rs_q;
	logic [GAIN_W-1:0]               lg_q;
	logic [GAIN_W-1:0]               rg_q;
	logic signed [SAMPLE_BITS-1:0]   ol_q;
	logic signed [SAMPLE_BITS-1:0]   or_q;
	logic signed [PROD_W-1:0]        prod_q;

	logic signed [MA_W-1:0]          mul_a;
	logic signed [MB_W-1:0]          mul_b;
	logic signed [PROD_W-1:0]        mul_p;
	logic [RATE_W-1:0]               step;
	logic [PH_W-1:0]                 phase_next;
	logic                            last_hit;
	logic                            out_free;
	logic                            res_load;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_shift(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] s;
		logic signed [SAMPLE_BITS-1:0] r;
		s = p >>> GAIN_SHIFT;
		if (s > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (s < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = s[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_GL: begin
				mul_a = {{(MA_W-GAIN_W){1'b0}}, gain.vol};
				mul_b = {1'b0, gain.pan_l};
			end
			S_GR: begin
				mul_a = {{(MA_W-GAIN_W){1'b0}}, gain.vol};
				mul_b = {1'b0, gain.pan_r};
			end
			S_ML: begin
				mul_a = MA_W'(ls_q);
				mul_b = {1'b0, lg_q};
			end
			S_MR: begin
				mul_a = MA_W'(rs_q);
				mul_b = {1'b0, rg_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p      = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign step       = (rate_step < MIN_STEP) ? MIN_STEP : rate_step;
	assign phase_next = phase_q + PH_W'(step);
	assign last_hit   = (phase_next >= PH_ONE) || (cnt_q == CNT_MAX);
	assign out_free   = !res_valid || !res_stall;
	assign res_load   = out_free && (state_q == S_EMIT || state_q == S_EOS);
	assign src_stall  = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= '0;
			cnt_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (src_valid) begin
						state_q <= kind ? S_EOS : S_GL;
					end
				end
				S_GL:  state_q <= S_GR;
				S_GR:  state_q <= S_ML;
				S_ML:  state_q <= S_MR;
				S_MR:  state_q <= S_CAP;
				S_CAP: begin
					cnt_q <= '0;
					if (phase_q >= PH_ONE) begin
						// dropped frame
						phase_q <= phase_q - PH_ONE;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q + MAX_OUT_LOG2'(1);
						if (last_hit) begin
							phase_q <= (phase_next >= PH_ONE) ? phase_next - PH_ONE : '0;
							state_q <= S_IDLE;
						end else begin
							phase_q <= phase_next;
						end
					end
				end
				S_EOS: begin
					if (out_free) begin
						phase_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && src_valid) begin
			ls_q <= left_sample;
			rs_q <= gain.mono ? left_sample : right_sample;
		end
		if (state_q == S_GR) begin
			lg_q <= prod_q[GAIN_SHIFT+GAIN_W-1:GAIN_SHIFT];
		end
		if (state_q == S_ML) begin
			rg_q <= prod_q[GAIN_SHIFT+GAIN_W-1:GAIN_SHIFT];
		end
		if (state_q == S_MR) begin
			ol_q <= sat_shift(prod_q);
		end
		if (state_q == S_CAP) begin
			or_q <= sat_shift(prod_q);
		end
		if (state_q == S_EMIT && out_free) begin
			out_left    <= ol_q;
			out_right   <= or_q;
			last        <= last_hit;
			stream_done <= 1'b0;
		end
		if (state_q == S_EOS && out_free) begin
			out_left    <= '0;
			out_right   <= '0;
			last        <= 1'b1;
			stream_done <= 1'b1;
		end
	end

	`RPG_ASSERT(a_emit_phase_below_one, (state_q == S_EMIT) |-> (phase_q < PH_ONE), "emit with phase at or above one")
	`RPG_ASSERT(a_last_ends_item, (state_q == S_EMIT && out_free && last_hit) |=> (state_q == S_IDLE && res_valid && last), "last result did not end the item")
	`RPG_ASSERT(a_done_silent, (res_valid && stream_done) |-> (last && out_left == '0 && out_right == '0), "end of stream result not silent")

endmodule
`default_nettype wire

### sv/resample_pan_gain_top.sv
// Nearest-neighbor sample rate converter with volume and pan.
// Source channel: src_valid/src_stall with kind, left_sample, right_sample.
// kind 0 is a source frame, kind 1 ends the stream. Results leave on
// res_valid/res_stall with out_left, out_right, last and stream_done.
// A frame gives zero or more results (at most 64); last marks the final one.
// End of stream gives one silent result with last and stream_done set and
// clears the phase. Configuration goes through the APB port, idle only;
// the user is bound to this, the block itself does not enforce it.
// Timing: one multiplier is shared over four products (two gains, two
// samples), so a frame passes the states GL, GR, ML, MR and CAP before
// its first result is loaded in EMIT, then one result per cycle while
// res_stall is low. A dropped frame goes back to idle from CAP, end of
// stream from EOS. The source is stalled for the whole of an item. The
// output register holds a result while res_stall is high; the sequencer
// waits on it. Reset clears the phase to zero and sets rate_step to one,
// volume to unity, pan to center and mono off.
`default_nettype none
module resample_pan_gain_top
	import rpg_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ADDR_W-1:0]             paddr,
	input  wire logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]                  prdata,
	output logic                               pready,
	input  wire logic                          src_valid,
	output logic                               src_stall,
	input  wire logic                          kind,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic signed [SAMPLE_BITS-1:0]      out_left,
	output logic signed [SAMPLE_BITS-1:0]      out_right,
	output logic                               last,
	output logic                               stream_done
);

	localparam int RATE_W = PHASE_FRAC_BITS + 5;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1) << PHASE_FRAC_BITS;

	logic [RATE_W-1:0]       rate_q;
	logic [GAIN_W-1:0]       vol_q;
	logic signed [PAN_W-1:0] pan_q;
	logic                    mono_q;
	logic                    wr_en;
	reg_idx_t                reg_idx;
	rpg_gain_t               gain;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			vol_q  <= VOLUME_RESET;
			pan_q  <= '0;
			mono_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RATE_STEP: rate_q <= pwdata[RATE_W-1:0];
				REG_VOLUME:    vol_q  <= pwdata[GAIN_W-1:0];
				REG_PAN:       pan_q  <= pwdata[PAN_W-1:0];
				REG_MONO:      mono_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RATE_STEP: prdata = DATA_W'(rate_q);
			REG_VOLUME:    prdata = DATA_W'(vol_q);
			REG_PAN:       prdata = DATA_W'(pan_q);
			REG_MONO:      prdata = DATA_W'(mono_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		gain.vol   = (vol_q > GAIN_ONE) ? GAIN_ONE : vol_q;
		gain.pan_l = clamp_gain($signed({2'b00, GAIN_ONE}) - (PAN_W+1)'(pan_q));
		gain.pan_r = clamp_gain($signed({2'b00, GAIN_ONE}) + (PAN_W+1)'(pan_q));
		gain.mono  = mono_q;
	end

	rpg_core #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.gain         (gain),
		.rate_step    (rate_q),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.kind         (kind),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_left     (out_left),
		.out_right    (out_right),
		.last         (last),
		.stream_done  (stream_done)
	);

endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench;
	import rpg_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_END = 1'b1;
	localparam longint PHASE_ONE = longint'(1) << PHASE_FRAC_BITS_DEF;
	localparam int MAX_RESULTS = 1 << MAX_OUT_LOG2;
	localparam longint MIN_STEP = PHASE_ONE / MAX_RESULTS;
	localparam longint UNITY = 32768;
	localparam longint SAMPLE_MAX = (longint'(1) << (SW - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam int SETTLE_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RATE_MAX = (1 << 21) - 1;

	typedef struct packed {
		logic signed [SW-1:0] out_l;
		logic signed [SW-1:0] out_r;
		logic                 last;
		logic                 done;
	} sample_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic src_valid = 1'b0;
	logic src_stall;
	logic kind = KIND_FRAME;
	logic signed [SW-1:0] left_sample = '0;
	logic signed [SW-1:0] right_sample = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [SW-1:0] out_left;
	logic signed [SW-1:0] out_right;
	logic last;
	logic stream_done;

	sample_result_t expected[$];
	longint rate_q = 65536;
	longint vol_q = 32768;
	longint pan_q = 0;
	logic mono_q = 1'b0;
	longint phase_acc = 0;
	int err_count = 0;
	int quiet_cycles = 0;
	int hold_len = 0;
	bit gaps_on = 1'b1;

	resample_pan_gain_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.kind(kind),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_left(out_left),
		.out_right(out_right),
		.last(last),
		.stream_done(stream_done)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		err_count++;
		$display("mismatch: %s", msg);
	endtask

	function automatic longint side_gain(input longint vol, input longint pan_g);
		if (pan_g < 0) begin
			pan_g = 0;
		end else if (pan_g > UNITY) begin
			pan_g = UNITY;
		end
		return (vol * pan_g) >> GAIN_SHIFT;
	endfunction

	function automatic logic signed [SW-1:0] apply_gain(input longint s, input longint g);
		longint p;
		p = (s * g) >>> GAIN_SHIFT;
		if (p > SAMPLE_MAX) begin
			p = SAMPLE_MAX;
		end else if (p < SAMPLE_MIN) begin
			p = SAMPLE_MIN;
		end
		return p[SW-1:0];
	endfunction

	task automatic predict_resample(input logic k, input logic signed [SW-1:0] l,
		input logic signed [SW-1:0] r);
		sample_result_t res;
		longint step, vol, gain_l, gain_r, nxt;
		logic signed [SW-1:0] src_r;
		int n;
		if (k == KIND_END) begin
			res.out_l = '0;
			res.out_r = '0;
			res.last = 1'b1;
			res.done = 1'b1;
			expected.push_back(res);
			phase_acc = 0;
		end else begin
			step = (rate_q < MIN_STEP) ? MIN_STEP : rate_q;
			vol = (vol_q > UNITY) ? UNITY : vol_q;
			gain_l = side_gain(vol, UNITY - pan_q);
			gain_r = side_gain(vol, UNITY + pan_q);
			src_r = mono_q ? l : r;
			n = 0;
			while (phase_acc < PHASE_ONE && n < MAX_RESULTS) begin
				nxt = phase_acc + step;
				res.out_l = apply_gain(l, gain_l);
				res.out_r = apply_gain(src_r, gain_r);
				res.last = (nxt >= PHASE_ONE) || (n == MAX_RESULTS - 1);
				res.done = 1'b0;
				expected.push_back(res);
				phase_acc = nxt;
				n++;
			end
			if (phase_acc >= PHASE_ONE) begin
				phase_acc -= PHASE_ONE;
			end else begin
				phase_acc = 0;
			end
		end
	endtask

	task automatic send_request(input logic k, input logic signed [SW-1:0] l,
		input logic signed [SW-1:0] r);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		src_valid <= 1'b1;
		kind <= k;
		left_sample <= l;
		right_sample <= r;
		do @(posedge clk); while (src_stall);
		predict_resample(k, l, r);
	endtask

	task automatic settle();
		src_valid <= 1'b0;
		while (expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RATE_STEP: rate_q = longint'(value[20:0]);
			REG_VOLUME:    vol_q = longint'(value[15:0]);
			REG_PAN:       pan_q = longint'($signed(value[16:0]));
			REG_MONO:      mono_q = value[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input int rate, input int vol, input int pan, input int mono);
		settle();
		write_reg(REG_RATE_STEP, rate);
		write_reg(REG_VOLUME, vol);
		write_reg(REG_PAN, pan);
		write_reg(REG_MONO, mono);
	endtask

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return SAMPLE_MAX[SW-1:0];
			1: return SAMPLE_MIN[SW-1:0];
			2: return '0;
			default: return SW'($urandom());
		endcase
	endfunction

	task automatic send_random_item();
		if ($urandom_range(0, 19) == 0) begin
			send_request(KIND_END, rand_sample(), rand_sample());
		end else begin
			send_request(KIND_FRAME, rand_sample(), rand_sample());
		end
	endtask

	task automatic test_directed();
		// defaults after reset: one result per frame, unity, center, stereo
		send_request(KIND_FRAME, 16'sh7FFF, 16'sh8000);
		send_request(KIND_FRAME, 16'sh8000, 16'sh7FFF);
		send_request(KIND_FRAME, 16'sh0000, 16'sh0000);
		send_request(KIND_FRAME, 16'sh5555, 16'shAAAA);
		send_request(KIND_FRAME, -16'sd1, 16'sd1);
		send_request(KIND_END, 16'sh1234, 16'sh4321);
		// rate below the floor: 64 results per frame, full left, mono
		apply_config(0, 32768, -32768, 1);
		send_request(KIND_FRAME, 16'sh8000, 16'sd123);
		send_request(KIND_FRAME, 16'sh7FFF, -16'sd5);
		send_request(KIND_END, 16'sh0000, 16'sh0000);
		// huge rate: frames get dropped; volume above unity, full right
		apply_config(RATE_MAX, 32'hFFFF, 32768, 0);
		send_request(KIND_FRAME, 16'sh7FFF, 16'sh8000);
		send_request(KIND_FRAME, 16'sh1111, 16'sh2222);
		send_request(KIND_FRAME, 16'sh3333, 16'sh4444);
		send_request(KIND_FRAME, 16'sh5555, 16'sh6666);
		send_request(KIND_END, 16'sh7777, 16'sh0888);
		send_request(KIND_FRAME, 16'sh8000, 16'sh7FFF);
		// exact floor step, pan far past full left
		apply_config(1024, 20000, -65536, 0);
		send_request(KIND_FRAME, 16'sh7FFF, 16'sh7FFF);
		send_request(KIND_FRAME, 16'sh8000, 16'sh8000);
		send_request(KIND_END, 16'sh0000, 16'sh0000);
		// fractional rate, mute, pan far past full right
		apply_config(98304, 0, 65535, 1);
		send_request(KIND_FRAME, 16'sh7FFF, 16'sh0001);
		send_request(KIND_FRAME, 16'sh8000, 16'sh0002);
		send_request(KIND_FRAME, 16'shAAAA, 16'sh5555);
		send_request(KIND_FRAME, 16'sh0001, 16'sh8000);
		send_request(KIND_END, 16'sh0000, 16'sh0000);
	endtask

	task automatic test_backpressure();
		apply_config(16384, 32768, 0, 0);
		hold_len = 400;
		repeat (24) send_request(KIND_FRAME, rand_sample(), rand_sample());
		settle();
	endtask

	task automatic test_random();
		int rate, vol, pan;
		repeat (7) begin
			case ($urandom_range(0, 5))
				0: rate = $urandom_range(0, 2047);
				1: rate = $urandom_range(1024, 8192);
				2, 3: rate = $urandom_range(8192, 131072);
				4: rate = $urandom_range(131072, 1048576);
				default: rate = $urandom_range(0, RATE_MAX);
			endcase
			vol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 32768);
			pan = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) - 65536
				: $urandom_range(0, 65536) - 32768;
			apply_config(rate, vol, pan, $urandom_range(0, 1));
			repeat (55) send_random_item();
		end
	endtask

	task automatic test_steady();
		gaps_on = 1'b0;
		apply_config($urandom_range(8192, 131072), $urandom_range(0, 32768),
			$urandom_range(0, 65536) - 32768, $urandom_range(0, 1));
		repeat (50) send_random_item();
	endtask

	initial begin : res_side
		int n;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		sample_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected.size() == 0) begin
				report_error($sformatf("unexpected result L=%0d R=%0d last=%0b done=%0b",
					out_left, out_right, last, stream_done));
			end else begin
				want = expected.pop_front();
				if (out_left !== want.out_l)
					report_error($sformatf("out_left %0d, want %0d", out_left, want.out_l));
				if (out_right !== want.out_r)
					report_error($sformatf("out_right %0d, want %0d", out_right, want.out_r));
				if (last !== want.last)
					report_error($sformatf("last %0b, want %0b", last, want.last));
				if (stream_done !== want.done)
					report_error($sformatf("stream_done %0b, want %0b", stream_done, want.done));
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (res_valid && !res_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		test_steady();
		settle();
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

### resample_pan_gain_top.f
+incdir+sv
sv/rpg_pkg.sv
sv/rpg_core.sv
sv/resample_pan_gain_top.sv
bench/testbench.sv
